FILE: src/c3f_pkg.sv
package c3f_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 11;
  localparam int SIZE_W     = 12;
  localparam int COEF_W     = 16;
  localparam int ROWREG_W   = 3 * COEF_W;
  localparam int TAPS       = 9;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_SIZE   = 3;
  localparam int Q_DEPTH    = 4;
  localparam int OUT_DEPTH  = 4;

  // products of an unsigned pixel and a signed coefficient, then sums of three
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = ROW_W + 2;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_COEF_T = 3'd2,
    REG_COEF_M = 3'd3,
    REG_COEF_B = 3'd4
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0]   WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = 12'd480;
  localparam logic [ROWREG_W-1:0] COEF_T_RST = 48'hFF00_FF00_FF00;
  localparam logic [ROWREG_W-1:0] COEF_M_RST = 48'hFF00_0800_FF00;
  localparam logic [ROWREG_W-1:0] COEF_B_RST = 48'hFF00_FF00_FF00;

  typedef logic [TAPS-1:0][PIX_W-1:0] win_t;
  typedef logic [2:0][ROWREG_W-1:0]   coef_t;

  // one interior pixel on its way from the front to the back
  typedef struct packed {
    win_t             win;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } res_t;

  // coefficient k of a row register, left one in the high bits
  function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROWREG_W-1:0] rowreg,
                                                       input int unsigned k);
    logic signed [COEF_W-1:0] v;
    v = rowreg[ROWREG_W-1-COEF_W*k -: COEF_W];
    return v;
  endfunction

endpackage

FILE: src/c3f_fifo.sv
module c3f_fifo
  import c3f_pkg::*;
#(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  T                           wr_data,
  input  logic                       rd_en,
  output T                           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            do_rd;

  assign empty   = (count == '0);
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !do_rd) begin
        count <= count + CW'(1);
      end else if (!wr_en && do_rd) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/c3f_front.sv
module c3f_front
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [PIX_W-1:0]              pixel_in,
  output logic                          full,
  input  logic [SIZE_W-1:0]             image_width,
  input  logic [SIZE_W-1:0]             image_height,
  input  logic [$clog2(Q_DEPTH+1)-1:0]  q_count,
  output logic                          q_push,
  output job_t                          q_job
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > SIZE_W) ? WW0 : SIZE_W;

  // older line in the high byte, newer line in the low byte
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd;

  logic [CW-1:0]     col_count;
  logic [POS_W-1:0]  row_count;
  logic [CW-1:0]     col_next;
  logic [POS_W-1:0]  row_next;

  logic [WW-1:0]     w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [CW-1:0]     c_cur;
  logic [POS_W-1:0]  r_cur;
  logic [WW-1:0]     c_inc;
  logic [SIZE_W-1:0] r_inc;
  logic              accept;

  logic              s1_valid;
  logic              s1_emit;
  logic [CW-1:0]     s1_addr;
  logic [PIX_W-1:0]  s1_px;
  logic [POS_W-1:0]  s1_row;
  logic [POS_W-1:0]  s1_col;
  logic              s1_done;

  win_t win;
  win_t win_next;

  assign full   = (int'(q_count) + int'(s1_valid)) >= Q_DEPTH;
  assign accept = push && !full;

  always_comb begin
    if (WW'(image_width) < WW'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < SIZE_W'(MIN_SIZE)) begin
      h_eff = SIZE_W'(MIN_SIZE);
    end else if (image_height > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // counters left out of range by a smaller size restart at zero
  always_comb begin
    c_cur = (WW'(col_count) >= w_eff) ? '0 : col_count;
    r_cur = (SIZE_W'(row_count) >= h_eff) ? '0 : row_count;
    c_inc = WW'(c_cur) + WW'(1);
    r_inc = SIZE_W'(r_cur) + SIZE_W'(1);
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[POS_W-1:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[c_cur];
    end
    if (s1_valid) begin
      line_mem[s1_addr] <= {line_rd[PIX_W-1:0], s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= c_cur;
      s1_px   <= pixel_in;
      s1_emit <= (r_cur >= POS_W'(2)) && (c_cur >= CW'(2));
      s1_row  <= r_cur - POS_W'(1);
      s1_col  <= POS_W'(CW'(c_cur - CW'(1)));
      s1_done <= (SIZE_W'(r_cur) == h_eff - SIZE_W'(1)) &&
                 (WW'(c_cur) == w_eff - WW'(1));
    end
  end

  // window slides left, new right column from both lines and the pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3]     = win[i*3+1];
      win_next[i*3 + 1] = win[i*3+2];
    end
    win_next[2] = line_rd[2*PIX_W-1:PIX_W];
    win_next[5] = line_rd[PIX_W-1:0];
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win <= win_next;
    end
  end

  assign q_push = s1_valid && s1_emit;
  assign q_job  = {win_next, s1_row, s1_col, s1_done};

`ifndef SYNTHESIS
  a_q_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (int'(q_count) < Q_DEPTH))
    else $error("front pushed a word into a full queue");
  a_s1_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach the line stage");
  a_interior: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (s1_row != '0) && (s1_col != '0))
    else $error("border pixel sent for filtering");
`endif

endmodule

FILE: src/c3f_back.sv
module c3f_back
  import c3f_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  coef_t            coef,
  input  logic             q_empty,
  input  job_t             q_job,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output res_t             res
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic                           b1_valid;
  logic signed [PROD_W-1:0]       prod [TAPS];
  logic [POS_W-1:0]               b1_row;
  logic [POS_W-1:0]               b1_col;
  logic                           b1_done;

  logic                           b2_valid;
  logic signed [ROW_W-1:0]        rsum [3];
  logic [POS_W-1:0]               b2_row;
  logic [POS_W-1:0]               b2_col;
  logic                           b2_done;

  logic signed [SUM_W-1:0]        total;
  logic [SUM_W-2:0]               shifted;
  res_t                           fin;
  logic [CNT_W-1:0]               out_count;

  // issue only when the output queue has a slot for everything in flight
  assign q_pop = !q_empty &&
                 ((int'(out_count) + int'(b1_valid) + int'(b2_valid)) < OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop;
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int t = 0; t < TAPS; t++) begin
        prod[t] <= $signed({1'b0, q_job.win[t]}) * coef_of(coef[t/3], t % 3);
      end
      b1_row  <= q_job.row;
      b1_col  <= q_job.col;
      b1_done <= q_job.done;
    end
    if (b1_valid) begin
      for (int i = 0; i < 3; i++) begin
        rsum[i] <= ROW_W'(prod[i*3]) + ROW_W'(prod[i*3+1]) + ROW_W'(prod[i*3+2]);
      end
      b2_row  <= b1_row;
      b2_col  <= b1_col;
      b2_done <= b1_done;
    end
  end

  assign total   = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
  assign shifted = total[SUM_W-2:0] >> COEF_FRAC_BITS;

  always_comb begin
    if (total[SUM_W-1]) begin
      fin.pix = '0;
    end else if (shifted > (SUM_W-1)'(255)) begin
      fin.pix = '1;
    end else begin
      fin.pix = shifted[PIX_W-1:0];
    end
    fin.row  = b2_row;
    fin.col  = b2_col;
    fin.done = b2_done;
  end

  c3f_fifo #(
    .T     (res_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (b2_valid),
    .wr_data (fin),
    .rd_en   (pop),
    .rd_data (res),
    .empty   (empty),
    .count   (out_count)
  );

`ifndef SYNTHESIS
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    b2_valid |-> (int'(out_count) < OUT_DEPTH))
    else $error("result word written into a full output queue");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> ##1 b2_valid)
    else $error("issued word lost in the multiply-add pipe");
`endif

endmodule

FILE: src/conv3x3_clamp_filter_top.sv
// Path: an accepted pixel is registered in the line stage, goes through the job queue,
// the product and row-sum registers and the output queue, where its filtered word
// waits on the result ports to be popped.
// Throughput: one pixel per cycle while full is low; border pixels leave no word behind.
// Rate is set by the line store, which takes one read and one write per pixel.
// Reset: counters cleared, sizes and kernel back to 640x480 and the edge kernel,
// queues emptied; the line stores keep their contents and need no clearing pass.
module conv3x3_clamp_filter_top
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH      = 2048,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 empty,
  input  logic                 pop,
  output logic [PIX_W-1:0]     pixel_out,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic                 frame_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROWREG_W-1:0]  cfg_data
);

  logic [SIZE_W-1:0]            image_width;
  logic [SIZE_W-1:0]            image_height;
  coef_t                        coef;

  logic                         q_push;
  job_t                         q_wjob;
  job_t                         q_rjob;
  logic                         q_pop;
  logic                         q_empty;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;
  res_t                         res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      coef[0]      <= COEF_T_RST;
      coef[1]      <= COEF_M_RST;
      coef[2]      <= COEF_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        REG_COEF_T: coef[0]      <= cfg_data;
        REG_COEF_M: coef[1]      <= cfg_data;
        REG_COEF_B: coef[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  c3f_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pixel_in     (pixel_in),
    .full         (full),
    .image_width  (image_width),
    .image_height (image_height),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_job        (q_wjob)
  );

  c3f_fifo #(
    .T     (job_t),
    .DEPTH (Q_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wjob),
    .rd_en   (q_pop),
    .rd_data (q_rjob),
    .empty   (q_empty),
    .count   (q_count)
  );

  c3f_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef),
    .q_empty (q_empty),
    .q_job   (q_rjob),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign pixel_out  = res.pix;
  assign out_row    = res.row;
  assign out_col    = res.col;
  assign frame_done = res.done;

endmodule

FILE: sim/conv3x3_clamp_filter_top_tb.sv
`timescale 1ns / 1ps

module conv3x3_clamp_filter_top_tb;
  import c3f_pkg::*;

  localparam int MAX_W          = 2048;
  localparam int FRAC_BITS      = 8;
  localparam int RAND_PIXELS    = 1470;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 400;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [COEF_W-1:0]    COEF_MAX     = 16'h7FFF;
  localparam logic [COEF_W-1:0]    COEF_MIN     = 16'h8000;
  localparam logic [COEF_W-1:0]    COEF_HALF    = 16'h0080;

  // filter model plus the words it still expects from the block
  class filter_scoreboard;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [ROWREG_W-1:0] kern [3];
    logic [PIX_W-1:0]    line_old [MAX_W];
    logic [PIX_W-1:0]    line_new [MAX_W];
    logic [PIX_W-1:0]    win [3][3];
    int unsigned         col;
    int unsigned         row;
    res_t                filtered_q [$];
    int                  errors;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      kern[0]    = COEF_T_RST;
      kern[1]    = COEF_M_RST;
      kern[2]    = COEF_B_RST;
      foreach (line_old[i]) begin
        line_old[i] = '0;
        line_new[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_SIZE) return MIN_SIZE;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_SIZE) return MIN_SIZE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // counters beyond a lowered bound count as zero
    function bit at_frame_start();
      return (col == 0 || col >= eff_width()) && (row == 0 || row >= eff_height());
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROWREG_W-1:0] val);
      case (idx)
        REG_WIDTH:  width_reg = val[SIZE_W-1:0];
        REG_HEIGHT: height_reg = val[SIZE_W-1:0];
        REG_COEF_T: kern[0] = val;
        REG_COEF_M: kern[1] = val;
        REG_COEF_B: kern[2] = val;
        default: ;
      endcase
    endfunction

    function void note_pixel(input logic [PIX_W-1:0] px);
      int unsigned              w;
      int unsigned              h;
      int unsigned              c;
      int unsigned              r;
      longint                   acc;
      logic signed [COEF_W-1:0] tap;
      res_t                     want;
      w = eff_width();
      h = eff_height();
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      c = col;
      r = row;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2]   = line_old[c];
      win[1][2]   = line_new[c];
      win[2][2]   = px;
      line_old[c] = line_new[c];
      line_new[c] = px;
      if (r >= 2 && c >= 2) begin
        acc = 0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            tap = kern[i][ROWREG_W-1-COEF_W*j -: COEF_W];
            acc += longint'(win[i][j]) * longint'(tap);
          end
        if (acc < 0) want.pix = '0;
        else if ((acc >>> FRAC_BITS) > 255) want.pix = 8'hFF;
        else want.pix = PIX_W'(acc >>> FRAC_BITS);
        want.row  = POS_W'(r - 1);
        want.col  = POS_W'(c - 1);
        want.done = (r == h - 1) && (c == w - 1);
        filtered_q.push_back(want);
      end
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row = r + 1;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_word(input logic [PIX_W-1:0] pix, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c, input logic d);
      res_t want;
      if (filtered_q.size() == 0) begin
        $error("unexpected word: pixel_out %0d row %0d col %0d", pix, r, c);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      if (pix !== want.pix) begin
        $error("pixel_out: expected %0d, got %0d", want.pix, pix);
        errors++;
      end
      if (r !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, r);
        errors++;
      end
      if (c !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, c);
        errors++;
      end
      if (d !== want.done) begin
        $error("frame_done: expected %0d, got %0d", want.done, d);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [PIX_W-1:0]     pixel_out;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;
  logic                 frame_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROWREG_W-1:0]  cfg_data = '0;

  filter_scoreboard sb = new();
  bit idle_on    = 1'b1;
  bit send_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  int pixels_sent = 0;
  int stall_cycles = 0;

  conv3x3_clamp_filter_top #(
    .MAX_WIDTH      (MAX_W),
    .COEF_FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel_in   (pixel_in),
    .empty      (empty),
    .pop        (pop),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_done (frame_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [PIX_W-1:0] next_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 8'hFF;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ROWREG_W-1:0] rand_kernel_row();
    logic [ROWREG_W-1:0] v;
    if ($urandom_range(0, 3) == 0) begin
      v = ROWREG_W'({$urandom(), $urandom()});
    end else begin
      for (int j = 0; j < 3; j++)
        v[ROWREG_W-1-COEF_W*j -: COEF_W] = COEF_W'($urandom_range(0, 1023) - 512);
    end
    return v;
  endfunction

  // size in the low bits; junk above it is meant to be dropped
  function automatic logic [ROWREG_W-1:0] size_word(input logic [SIZE_W-1:0] s);
    logic [ROWREG_W-SIZE_W-1:0] junk;
    junk = $urandom_range(0, 1) ? (ROWREG_W-SIZE_W)'({$urandom(), $urandom()}) : '0;
    return {junk, s};
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] px);
    if ($urandom_range(0, 149) == 0) send_quiet = !send_quiet;
    if (idle_on && !send_quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    push     <= 1'b1;
    pixel_in <= px;
    do @(posedge clk); while (full);
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic push_to_frame_end();
    do push_pixel(next_pixel()); while (!sb.at_frame_start());
  endtask

  // all words home, then room for a border pixel still in flight
  task automatic quiesce();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // leaves valid high so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROWREG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [ROWREG_W-1:0] t, input logic [ROWREG_W-1:0] m,
                           input logic [ROWREG_W-1:0] b);
    quiesce();
    write_reg(REG_WIDTH, size_word(w));
    write_reg(REG_HEIGHT, size_word(h));
    write_reg(REG_COEF_T, t);
    write_reg(REG_COEF_M, m);
    write_reg(REG_COEF_B, b);
    cfg_release();
  endtask

  // result side
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) sink_quiet = !sink_quiet;
      if (stall_left == 0 && idle_on && !sink_quiet && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_word(pixel_out, out_row, out_col, frame_done);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("conv3x3_clamp_filter_top regression: fail");
      $finish;
    end
  end

  initial begin
    int               base;
    int               n;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes and edge kernel: part of a row at 640, then narrow so the column
    // restarts at zero, and a few rows go through the reset kernel
    repeat (5) push_pixel(next_pixel());
    quiesce();
    write_reg(REG_WIDTH, size_word(12'd3));
    cfg_release();
    repeat (3 * 6) push_pixel(next_pixel());

    // sizes below the minimum clamp to 3; saturation high
    configure(12'd0, 12'd1, {3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
    repeat (9) push_pixel(8'hFF);
    // large negative sum gives zero
    configure(12'd2, 12'd2, {3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
    repeat (9) push_pixel(8'hFF);
    // half weight on the centre: fraction truncated; spare indexes are ignored
    quiesce();
    write_reg(REG_WIDTH, size_word(12'd3));
    write_reg(REG_HEIGHT, size_word(12'd3));
    write_reg(REG_COEF_T, '0);
    write_reg(REG_COEF_M, {16'h0000, COEF_HALF, 16'h0000});
    write_reg(REG_COEF_B, '0);
    for (int k = IDX_SPARE_LO; k <= IDX_SPARE_HI; k++)
      write_reg(CFG_IDX_W'(k), ROWREG_W'({$urandom(), $urandom()}));
    cfg_release();
    for (int k = 0; k < 9; k++) push_pixel(k == 4 ? 8'hFF : 8'h00);

    // height through the upper clamp: first rows of the tallest frame
    configure(12'd3, 12'hFFF, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    repeat (3 * 10) push_pixel(next_pixel());

    base = pixels_sent;
    while (pixels_sent - base < RAND_PIXELS) begin
      if (pixels_sent - base > RAND_PIXELS * 4 / 5) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       w = SIZE_W'($urandom_range(0, 2));
        1, 2:    w = SIZE_W'($urandom_range(11, 40));
        default: w = SIZE_W'($urandom_range(3, 10));
      endcase
      h = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom_range(0, 2))
                                      : SIZE_W'($urandom_range(3, 8));
      configure(w, h, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      repeat ($urandom_range(1, 2)) push_to_frame_end();
      if ($urandom_range(0, 2) == 0) begin
        // shrink the width mid-frame, height may change too; counters past the new bound restart at zero
        n = $urandom_range(1, sb.eff_width() * sb.eff_height() - 1);
        repeat (n) push_pixel(next_pixel());
        quiesce();
        write_reg(REG_WIDTH, size_word(SIZE_W'($urandom_range(0, sb.eff_width()))));
        if ($urandom_range(0, 1)) write_reg(REG_HEIGHT, size_word(SIZE_W'($urandom_range(0, 10))));
        if ($urandom_range(0, 1)) write_reg(REG_COEF_M, rand_kernel_row());
        cfg_release();
        push_to_frame_end();
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0)
      $display("conv3x3_clamp_filter_top regression: pass");
    else
      $display("conv3x3_clamp_filter_top regression: fail");
    $finish;
  end

endmodule
